FILE: rtl/spirw_pkg.sv
// types and constants shared by the spi register window slave
// no dependencies; compile first
package spirw_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [2:0] req_code_t;

  localparam int CFG_W     = 9;
  localparam int COUNT_W   = 32;
  localparam int ADDR_BITS = 7;

  localparam req_code_t REQ_SEL_FALL = 3'd0;
  localparam req_code_t REQ_SPI_BYTE = 3'd1;
  localparam req_code_t REQ_SEL_RISE = 3'd2;
  localparam req_code_t REQ_LOCAL_RD = 3'd3;
  localparam req_code_t REQ_LOCAL_WR = 3'd4;

  localparam byte_t REPLY_MORE = 8'hA0;
  localparam byte_t ADDR_MASK  = 8'h7F;

  typedef enum logic [2:0] {
    OP_SEL_FALL,
    OP_SPI_BYTE,
    OP_SEL_RISE,
    OP_LOCAL_RD,
    OP_LOCAL_WR,
    OP_NONE
  } op_t;

  typedef struct packed {
    op_t   op;
    logic  in_range;
    byte_t rx_byte;
    byte_t local_addr;
    byte_t local_data;
  } cmd_t;

  typedef struct packed {
    logic               tx_valid;
    byte_t              tx_byte;
    byte_t              local_rd_data;
    logic [COUNT_W-1:0] write_count;
  } rsp_t;

endpackage

FILE: rtl/spirw_if.sv
// request and response channel interfaces with valid/ready handshake
// depends on spirw_pkg
interface spirw_req_if
  import spirw_pkg::*;
();
  logic      valid;
  logic      ready;
  req_code_t req_type;
  byte_t     rx_byte;
  byte_t     local_addr;
  byte_t     local_data;

  modport source(output valid, output req_type, output rx_byte, output local_addr,
                 output local_data, input ready);
  modport sink(input valid, input req_type, input rx_byte, input local_addr,
               input local_data, output ready);
endinterface

interface spirw_rsp_if
  import spirw_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               tx_valid;
  byte_t              tx_byte;
  byte_t              local_rd_data;
  logic [COUNT_W-1:0] write_count;

  modport source(output valid, output tx_valid, output tx_byte, output local_rd_data,
                 output write_count, input ready);
  modport sink(input valid, input tx_valid, input tx_byte, input local_rd_data,
               input write_count, output ready);
endinterface

FILE: rtl/spirw_ram.sv
// generic single-port ram with registered read data
// no dependencies
module spirw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                       wdata,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: rtl/spirw_front.sv
// front end: takes request beats, decodes them into commands for the queue
// depends on spirw_pkg and spirw_req_if
module spirw_front
  import spirw_pkg::*;
#(
  parameter int WINDOW_DEPTH = 256
) (
  spirw_req_if.sink                      req,
  input  logic [$clog2(WINDOW_DEPTH+1)-1:0] len,
  input  logic                           hold,
  input  logic                           push_ready,
  output logic                           push_valid,
  output cmd_t                           push_cmd
);

  always_comb begin
    push_cmd.rx_byte    = req.rx_byte;
    push_cmd.local_addr = req.local_addr;
    push_cmd.local_data = req.local_data;
    push_cmd.in_range   = 32'(req.local_addr) < 32'(len);
    case (req.req_type)
      REQ_SEL_FALL: push_cmd.op = OP_SEL_FALL;
      REQ_SPI_BYTE: push_cmd.op = OP_SPI_BYTE;
      REQ_SEL_RISE: push_cmd.op = OP_SEL_RISE;
      REQ_LOCAL_RD: push_cmd.op = OP_LOCAL_RD;
      REQ_LOCAL_WR: push_cmd.op = OP_LOCAL_WR;
      default:      push_cmd.op = OP_NONE;
    endcase
  end

  // no beats taken while the window is being cleared
  assign req.ready  = push_ready && !hold;
  assign push_valid = req.valid && push_ready && !hold;

endmodule

FILE: rtl/spirw_queue.sv
// two-entry command queue between front and back end
// depends on spirw_pkg
module spirw_queue
  import spirw_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  input  cmd_t push_cmd,
  output logic push_ready,
  input  logic pop,
  output logic pop_valid,
  output cmd_t pop_cmd
);

  cmd_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign push_ready = count != 2'd2;
  assign pop_valid  = count != 2'd0;
  assign pop_cmd    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push_valid) begin
        entries[wr_ptr] <= push_cmd;
        wr_ptr          <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push_valid && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push_valid) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

FILE: rtl/spirw_back.sv
// back end: executes commands against the window ram, holds transaction state
// depends on spirw_pkg and spirw_ram
module spirw_back
  import spirw_pkg::*;
#(
  parameter int WINDOW_DEPTH = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [$clog2(WINDOW_DEPTH+1)-1:0] len,
  input  logic                              q_valid,
  input  cmd_t                              q_cmd,
  output logic                              q_pop,
  output logic                              clearing,
  output logic                              out_valid,
  output rsp_t                              out_data,
  input  logic                              out_ready
);

  localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int LW = $clog2(WINDOW_DEPTH + 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_ADDR,
    ST_RD_WAIT,
    ST_EMIT
  } state_t;

  state_t               state;
  cmd_t                 cmd;
  logic [AW-1:0]        position;
  logic                 write_flag;
  logic                 awaiting;
  logic [COUNT_W-1:0]   write_counter;
  logic [AW-1:0]        clr_addr;
  logic [LW-1:0]        rem;
  logic [ADDR_BITS-1:0] shreg;
  logic [2:0]           div_cnt;
  logic                 res_tx_valid;
  byte_t                res_tx;
  byte_t                res_lrd;

  logic          ram_we;
  logic [AW-1:0] ram_addr;
  byte_t         ram_wdata;
  byte_t         ram_rdata;
  logic [LW:0]   trial;

  function automatic logic [AW-1:0] next_pos(input logic [AW-1:0] p,
                                             input logic [LW-1:0] l);
    logic [LW-1:0] s;
    s = LW'(p) + LW'(1);
    return (s >= l) ? '0 : AW'(s);
  endfunction

  assign q_pop    = (state == ST_IDLE) && q_valid;
  assign clearing = state == ST_CLEAR;
  assign trial    = {rem, shreg[ADDR_BITS-1]};

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = position;
    ram_wdata = cmd.rx_byte;
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_addr;
        ram_wdata = '0;
      end
      ST_EXEC: begin
        case (cmd.op)
          OP_SPI_BYTE: ram_we = !awaiting && write_flag;
          OP_LOCAL_RD: ram_addr = AW'(cmd.local_addr);
          OP_LOCAL_WR: begin
            ram_addr  = AW'(cmd.local_addr);
            ram_we    = cmd.in_range;
            ram_wdata = cmd.local_data;
          end
          default: ram_we = 1'b0;
        endcase
      end
      ST_ADDR: ram_addr = AW'(rem);
      default: ram_we = 1'b0;
    endcase
  end

  spirw_ram #(
    .WIDTH(8),
    .DEPTH(WINDOW_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_addr      <= '0;
      position      <= '0;
      write_flag    <= 1'b0;
      awaiting      <= 1'b0;
      write_counter <= '0;
      out_valid     <= 1'b0;
    end else begin
      // in the emit state the output register is reloaded instead
      if (out_valid && out_ready && (state != ST_EMIT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(WINDOW_DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (q_valid) begin
            cmd          <= q_cmd;
            res_tx_valid <= 1'b0;
            res_tx       <= '0;
            res_lrd      <= '0;
            // a length lowered mid-transaction leaves a stale position
            if (LW'(position) >= len) begin
              position <= '0;
            end
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          case (cmd.op)
            OP_SEL_FALL: begin
              awaiting <= 1'b1;
              state    <= ST_EMIT;
            end
            OP_SEL_RISE: begin
              if (write_flag) begin
                write_counter <= write_counter + COUNT_W'(1);
              end
              state <= ST_EMIT;
            end
            OP_SPI_BYTE: begin
              res_tx_valid <= 1'b1;
              if (awaiting) begin
                awaiting   <= 1'b0;
                write_flag <= cmd.rx_byte[7];
                rem        <= '0;
                shreg      <= ADDR_BITS'(cmd.rx_byte & ADDR_MASK);
                div_cnt    <= '0;
                state      <= ST_DIV;
              end else begin
                position <= next_pos(position, len);
                if (write_flag) begin
                  res_tx <= REPLY_MORE;
                  state  <= ST_EMIT;
                end else begin
                  state <= ST_RD_WAIT;
                end
              end
            end
            OP_LOCAL_RD: begin
              if (cmd.in_range) begin
                state <= ST_RD_WAIT;
              end else begin
                state <= ST_EMIT;
              end
            end
            default: state <= ST_EMIT;
          endcase
        end
        ST_DIV: begin
          // restoring remainder, one address bit a cycle
          if (trial >= {1'b0, len}) begin
            rem <= LW'(trial - {1'b0, len});
          end else begin
            rem <= LW'(trial);
          end
          shreg   <= shreg << 1;
          div_cnt <= div_cnt + 3'd1;
          if (div_cnt == 3'(ADDR_BITS - 1)) begin
            state <= ST_ADDR;
          end
        end
        ST_ADDR: begin
          if (write_flag) begin
            position <= AW'(rem);
            res_tx   <= REPLY_MORE;
            state    <= ST_EMIT;
          end else begin
            position <= next_pos(AW'(rem), len);
            state    <= ST_RD_WAIT;
          end
        end
        ST_RD_WAIT: begin
          if (cmd.op == OP_SPI_BYTE) begin
            res_tx <= ram_rdata;
          end else begin
            res_lrd <= ram_rdata;
          end
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid              <= 1'b1;
            out_data.tx_valid      <= res_tx_valid;
            out_data.tx_byte       <= res_tx;
            out_data.local_rd_data <= res_lrd;
            out_data.write_count   <= write_counter;
            state                  <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_no_pop_while_clearing: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !q_pop)
    else $error("command taken during clearing pass");

  a_position_in_window: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (LW'(position) < len))
    else $error("position outside window");

  a_remainder_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV || state == ST_ADDR) |-> (rem < len))
    else $error("address remainder not reduced");

  a_counter_only_on_rise: assert property (@(posedge clk) disable iff (rst)
    !(state == ST_EXEC && cmd.op == OP_SEL_RISE) |=> $stable(write_counter))
    else $error("write counter moved without select rise");

  a_reply_excludes_local: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.tx_valid) |-> (out_data.local_rd_data == '0))
    else $error("spi reply carries local read data");

endmodule

FILE: rtl/spi_register_window_slave.sv
// spi register window slave: a beat passes the execute and emit states, with a ram read
// state between for a window read; an address byte first runs the 7-step remainder loop
// and the address state, plus the read state in read mode; the back end takes one beat at
// a time, the two-entry queue takes beats until full; reset clears the window ram one
// entry a cycle, taking no beat meanwhile; configuration writes are taken at any time
// depends on spirw_pkg, spirw_if, spirw_front, spirw_queue, spirw_back
module spi_register_window_slave
  import spirw_pkg::*;
#(
  parameter int WINDOW_DEPTH = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  spirw_req_if.sink        req,
  spirw_rsp_if.source      rsp
);

  localparam int LW = $clog2(WINDOW_DEPTH + 1);

  logic [LW-1:0] len;
  logic          bad_len;
  logic          push_valid;
  logic          push_ready;
  cmd_t          push_cmd;
  logic          q_valid;
  logic          q_pop;
  cmd_t          q_cmd;
  logic          clearing;
  rsp_t          out_data;

  // out-of-range lengths fall back to the full window
  assign bad_len = (cfg_wdata == '0) || (32'(cfg_wdata) > 32'(WINDOW_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      len <= LW'(WINDOW_DEPTH);
    end else if (cfg_we) begin
      len <= bad_len ? LW'(WINDOW_DEPTH) : LW'(cfg_wdata);
    end
  end

  spirw_front #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) u_front (
    .req       (req),
    .len       (len),
    .hold      (clearing),
    .push_ready(push_ready),
    .push_valid(push_valid),
    .push_cmd  (push_cmd)
  );

  spirw_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(push_valid),
    .push_cmd  (push_cmd),
    .push_ready(push_ready),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_cmd   (q_cmd)
  );

  spirw_back #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .len      (len),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop),
    .clearing (clearing),
    .out_valid(rsp.valid),
    .out_data (out_data),
    .out_ready(rsp.ready)
  );

  assign rsp.tx_valid      = out_data.tx_valid;
  assign rsp.tx_byte       = out_data.tx_byte;
  assign rsp.local_rd_data = out_data.local_rd_data;
  assign rsp.write_count   = out_data.write_count;

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for spi_register_window_slave: directed and random request beats
// checked against an in-bench model of the byte window; uses spirw_pkg and spirw_if
module testbench;
  import spirw_pkg::*;

  localparam int WINDOW_DEPTH = 256;

  typedef struct {
    req_code_t req_type;
    byte_t     rx_byte;
    byte_t     local_addr;
    byte_t     local_data;
  } spi_req_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  spirw_req_if req_if();
  spirw_rsp_if rsp_if();

  spi_register_window_slave #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .req      (req_if),
    .rsp      (rsp_if)
  );

  // model of the window and transaction state
  byte_t              win_mem [WINDOW_DEPTH];
  int                 cur_pos;
  bit                 wr_mode;
  bit                 addr_pending;
  logic [COUNT_W-1:0] wr_txn_count;
  logic [CFG_W-1:0]   win_len_reg;

  spi_req_t pending_reqs[$];
  rsp_t     expected_replies[$];
  int       src_idle_pct;
  int       snk_stall_pct;
  int       n_errors;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int active_length();
    if (win_len_reg == 0 || win_len_reg > WINDOW_DEPTH) return WINDOW_DEPTH;
    return int'(win_len_reg);
  endfunction

  function automatic byte_t rand_byte();
    return byte_t'($urandom);
  endfunction

  function automatic rsp_t window_predict(spi_req_t it);
    rsp_t r;
    int   len;
    len = active_length();
    r = '0;
    // length may have been lowered under an open transaction
    if (cur_pos >= len) cur_pos = 0;
    case (it.req_type)
      REQ_SEL_FALL: addr_pending = 1'b1;
      REQ_SPI_BYTE: begin
        r.tx_valid = 1'b1;
        if (addr_pending) begin
          addr_pending = 1'b0;
          cur_pos = int'(it.rx_byte & ADDR_MASK) % len;
          wr_mode = it.rx_byte[7];
          if (wr_mode) begin
            r.tx_byte = REPLY_MORE;
          end else begin
            r.tx_byte = win_mem[cur_pos];
            cur_pos = (cur_pos + 1 >= len) ? 0 : cur_pos + 1;
          end
        end else begin
          if (wr_mode) begin
            win_mem[cur_pos] = it.rx_byte;
            r.tx_byte = REPLY_MORE;
          end else begin
            r.tx_byte = win_mem[cur_pos];
          end
          cur_pos = (cur_pos + 1 >= len) ? 0 : cur_pos + 1;
        end
      end
      REQ_SEL_RISE: if (wr_mode) wr_txn_count = wr_txn_count + 1;
      REQ_LOCAL_RD: if (int'(it.local_addr) < len) r.local_rd_data = win_mem[it.local_addr];
      REQ_LOCAL_WR: if (int'(it.local_addr) < len) win_mem[it.local_addr] = it.local_data;
      default: ;
    endcase
    r.write_count = wr_txn_count;
    return r;
  endfunction

  function automatic void push_item(req_code_t code, byte_t rx, byte_t la, byte_t ld);
    spi_req_t it;
    it.req_type   = code;
    it.rx_byte    = rx;
    it.local_addr = la;
    it.local_data = ld;
    pending_reqs.push_back(it);
  endfunction

  // local read or write, at least half of them inside the window
  function automatic void push_local(int len);
    byte_t la;
    la = ($urandom_range(1) == 0) ? byte_t'($urandom_range(len - 1)) : byte_t'($urandom);
    push_item($urandom_range(1) ? REQ_LOCAL_WR : REQ_LOCAL_RD, rand_byte(), la, rand_byte());
  endfunction

  // mostly well-formed transactions with random content, also local accesses and noise
  task automatic fill_random(int n_items);
    int count;
    int len;
    int n_data;
    int r;
    count = 0;
    len = active_length();
    // a data beat straight away continues whatever transaction was left open
    push_item(REQ_SPI_BYTE, rand_byte(), rand_byte(), rand_byte());
    while (count < n_items) begin
      r = $urandom_range(99);
      if (r < 70) begin
        push_item(REQ_SEL_FALL, rand_byte(), rand_byte(), rand_byte());
        push_item(REQ_SPI_BYTE, rand_byte(), rand_byte(), rand_byte());
        n_data = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 8);
        for (int i = 0; i < n_data; i++) begin
          if ($urandom_range(99) < 10) push_local(len);
          push_item(REQ_SPI_BYTE, rand_byte(), rand_byte(), rand_byte());
        end
        if ($urandom_range(9) != 0) push_item(REQ_SEL_RISE, rand_byte(), rand_byte(), rand_byte());
        count += 3 + n_data;
      end else if (r < 88) begin
        push_local(len);
        count++;
      end else if (r < 97) begin
        case ($urandom_range(2))
          0: push_item(REQ_SPI_BYTE, rand_byte(), rand_byte(), rand_byte());
          1: push_item(REQ_SEL_RISE, rand_byte(), rand_byte(), rand_byte());
          default: push_item(REQ_SEL_FALL, rand_byte(), rand_byte(), rand_byte());
        endcase
        count++;
      end else begin
        push_item(req_code_t'($urandom_range(REQ_LOCAL_WR + 1, 7)), rand_byte(), rand_byte(),
                  rand_byte());
        count++;
      end
    end
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() > 0 || req_if.valid || expected_replies.size() > 0)
      @(posedge clk);
  endtask

  task automatic report_mismatch(string field, logic [31:0] exp_v, logic [31:0] act_v);
    $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, field, exp_v, act_v);
    n_errors++;
  endtask

  // request driver
  always @(posedge clk) begin : drive
    spi_req_t acc_item;
    spi_req_t nxt_item;
    if (rst) begin
      req_if.valid      <= 1'b0;
      req_if.req_type   <= REQ_SEL_FALL;
      req_if.rx_byte    <= '0;
      req_if.local_addr <= '0;
      req_if.local_data <= '0;
    end else begin
      if (req_if.valid && req_if.ready) begin
        acc_item.req_type   = req_if.req_type;
        acc_item.rx_byte    = req_if.rx_byte;
        acc_item.local_addr = req_if.local_addr;
        acc_item.local_data = req_if.local_data;
        expected_replies.push_back(window_predict(acc_item));
      end
      if (!req_if.valid || req_if.ready) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          nxt_item = pending_reqs.pop_front();
          req_if.valid      <= 1'b1;
          req_if.req_type   <= nxt_item.req_type;
          req_if.rx_byte    <= nxt_item.rx_byte;
          req_if.local_addr <= nxt_item.local_addr;
          req_if.local_data <= nxt_item.local_data;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // response monitor
  always @(posedge clk) begin : watch
    rsp_t exp_r;
    rsp_if.ready <= ($urandom_range(99) >= snk_stall_pct);
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (expected_replies.size() == 0) begin
        $display("%0t: response beat with nothing expected", $realtime);
        n_errors++;
      end else begin
        exp_r = expected_replies.pop_front();
        if (rsp_if.tx_valid !== exp_r.tx_valid)
          report_mismatch("tx_valid", 32'(exp_r.tx_valid), 32'(rsp_if.tx_valid));
        if (rsp_if.tx_byte !== exp_r.tx_byte)
          report_mismatch("tx_byte", 32'(exp_r.tx_byte), 32'(rsp_if.tx_byte));
        if (rsp_if.local_rd_data !== exp_r.local_rd_data)
          report_mismatch("local_rd_data", 32'(exp_r.local_rd_data),
                          32'(rsp_if.local_rd_data));
        if (rsp_if.write_count !== exp_r.write_count)
          report_mismatch("write_count", exp_r.write_count, rsp_if.write_count);
      end
    end
  end

  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    int len_plan [12];
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    src_idle_pct = 0;
    snk_stall_pct = 0;
    n_errors = 0;
    foreach (win_mem[i]) win_mem[i] = '0;
    cur_pos = 0;
    wr_mode = 1'b0;
    addr_pending = 1'b0;
    wr_txn_count = '0;
    win_len_reg = 9'd256;
    len_plan = '{1, 0, 511, 257, 128, 2, 127, 255, 64, 256, 3, 1};
    len_plan[11] = $urandom_range(1, 511);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: byte before any select fall reads in read mode
    push_item(REQ_SPI_BYTE, 8'hFF, 8'h00, 8'h00);
    push_item(REQ_SEL_RISE, 8'h00, 8'hFF, 8'hFF);
    push_item(REQ_LOCAL_WR, 8'h00, 8'h00, 8'hFF);
    push_item(REQ_LOCAL_WR, 8'hFF, 8'hFF, 8'h5A);
    push_item(REQ_LOCAL_WR, 8'h00, 8'h7F, 8'h80);
    // write transaction at the top of the address range, then repeated select rises
    push_item(REQ_SEL_FALL, 8'h00, 8'h00, 8'h00);
    push_item(REQ_SPI_BYTE, 8'hFF, 8'h00, 8'h00);
    push_item(REQ_SPI_BYTE, 8'h00, 8'h00, 8'h00);
    push_item(REQ_SPI_BYTE, 8'hFF, 8'h00, 8'h00);
    push_item(REQ_SEL_RISE, 8'h00, 8'h00, 8'h00);
    push_item(REQ_SEL_RISE, 8'h00, 8'h00, 8'h00);
    // read back across the same positions
    push_item(REQ_SEL_FALL, 8'h00, 8'h00, 8'h00);
    push_item(REQ_SPI_BYTE, 8'h7F, 8'h00, 8'h00);
    push_item(REQ_SPI_BYTE, 8'h00, 8'h00, 8'h00);
    push_item(REQ_SEL_RISE, 8'h00, 8'h00, 8'h00);
    push_item(REQ_LOCAL_RD, 8'h00, 8'h00, 8'h00);
    push_item(REQ_LOCAL_RD, 8'h00, 8'hFF, 8'h00);
    push_item(REQ_LOCAL_RD, 8'h00, 8'h80, 8'h00);
    push_item(req_code_t'(7), 8'hFF, 8'hFF, 8'hFF);
    push_item(REQ_SEL_FALL, 8'h00, 8'h00, 8'h00);
    push_item(REQ_SPI_BYTE, 8'h00, 8'h00, 8'h00);
    // leave a write open at a high position so a shorter window finds it stale
    push_item(REQ_SEL_FALL, 8'h00, 8'h00, 8'h00);
    push_item(REQ_SPI_BYTE, 8'hF0, 8'h00, 8'h00);
    push_item(REQ_SPI_BYTE, 8'h3C, 8'h00, 8'h00);

    for (int p = 0; p < 12; p++) begin
      wait_idle();
      repeat (16) @(posedge clk);
      cfg_we <= 1'b1;
      cfg_wdata <= CFG_W'(len_plan[p]);
      win_len_reg = CFG_W'(len_plan[p]);
      @(posedge clk);
      cfg_we <= 1'b0;
      case (p % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 50; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 50; end
        default: begin src_idle_pct = 37; snk_stall_pct = 37; end
      endcase
      fill_random(150);
    end

    wait_idle();
    repeat (20) @(posedge clk);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/spirw_pkg.sv
rtl/spirw_if.sv
rtl/spirw_ram.sv
rtl/spirw_front.sv
rtl/spirw_queue.sv
rtl/spirw_back.sv
rtl/spi_register_window_slave.sv
test/testbench.sv
